@@ rtl/bfd_pkg.sv @@
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared types, widths and register codes of the box filter downsampler.
// ----------------------------------------------------------------------------
package bfd_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int SUM_BITS     = 32;
    localparam int MAX_FACTOR   = 16;
    localparam int MAX_WIDTH    = 4096;
    localparam int HEIGHT_LIMIT = 4096;

    localparam int FACTOR_BITS  = 5;
    localparam int SIZE_BITS    = 13;
    localparam int POS_BITS     = 12;
    localparam int SUB_BITS     = 4;
    localparam int DIVISOR_BITS = 9;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 13;

    localparam logic [CFG_IDX_BITS-1:0] REG_FACTOR      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_HEIGHT = 2'd2;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [SUM_BITS-1:0]    t_sum;
    typedef logic [FACTOR_BITS-1:0]        t_factor;
    typedef logic [SIZE_BITS-1:0]          t_size;
    typedef logic [CFG_IDX_BITS-1:0]       t_cfg_idx;
    typedef logic [CFG_DATA_BITS-1:0]      t_cfg_data;

endpackage

@@ rtl/bfd_in_if.sv @@
// ----------------------------------------------------------------------------
// bfd_in_if
// Sample stream channel: one signed fixed-point sample per word.
// ----------------------------------------------------------------------------
interface bfd_in_if;
    logic             valid;
    logic             ready;
    bfd_pkg::t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

@@ rtl/bfd_out_if.sv @@
// ----------------------------------------------------------------------------
// bfd_out_if
// Result channel: one block mean and its end-of-frame flag per word.
// ----------------------------------------------------------------------------
interface bfd_out_if;
    logic             valid;
    logic             ready;
    bfd_pkg::t_sample block_mean;
    logic             frame_last;

    modport source (output valid, output block_mean, output frame_last, input ready);
    modport sink   (input valid, input block_mean, input frame_last, output ready);
endinterface

@@ rtl/bfd_cfg_if.sv @@
// ----------------------------------------------------------------------------
// bfd_cfg_if
// Configuration write channel: register index and write data per word.
// ----------------------------------------------------------------------------
interface bfd_cfg_if;
    logic               valid;
    logic               ready;
    bfd_pkg::t_cfg_idx  index;
    bfd_pkg::t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/box_filter_downsample.sv @@
// ----------------------------------------------------------------------------
// box_filter_downsample
// Box-filter decimation of a raster frame by an integer factor.
//
// i_in carries samples in raster order; o_out carries one block mean per
// factor x factor block, with frame_last on the final mean of the frame.
// i_cfg writes factor (0), grid_width (1) and grid_height (2); any write to
// these restarts the frame. i_cfg is always ready.
// Partial block sums sit in a 4096 x 32 column-sum RAM (registered read).
// Throughput: one sample per cycle, except a sample at a block's right edge
// also takes a RAM read-modify-write state (S_RD), and a sample closing a
// block runs through accept, RAM update, the divider and the result load,
// which waits in S_OUT while the output register is still full.
// Reset restores factor 2, 256 x 256 and the frame start; the RAM is not
// cleared, since the first row of each block band overwrites its entry.
// A finished mean waits in the output register; while o_out stalls, samples
// keep flowing until the next mean is ready to be loaded.
// ----------------------------------------------------------------------------
module box_filter_downsample (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bfd_in_if.sink     i_in,
    bfd_out_if.source  o_out,
    bfd_cfg_if.sink    i_cfg
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    localparam int PB = bfd_pkg::POS_BITS;
    localparam int SB = bfd_pkg::SIZE_BITS;
    localparam int FB = bfd_pkg::FACTOR_BITS;
    localparam int UB = bfd_pkg::SUB_BITS;
    localparam int DB = bfd_pkg::DIVISOR_BITS;

    logic [1:0]           r_state, n_state;
    bfd_pkg::t_factor     r_factor, n_factor;
    bfd_pkg::t_size       r_width, n_width;
    bfd_pkg::t_size       r_height, n_height;

    logic [PB-1:0]        r_col, n_col;
    logic [UB-1:0]        r_cib, n_cib;
    logic [PB-1:0]        r_bc, n_bc;
    logic [SB-1:0]        r_cbeg, n_cbeg;
    logic [PB-1:0]        r_row, n_row;
    logic [UB-1:0]        r_rib, n_rib;
    logic [SB-1:0]        r_rbeg, n_rbeg;
    bfd_pkg::t_sum        r_rsum, n_rsum;

    bfd_pkg::t_sum        r_pend_sum, n_pend_sum;
    logic [PB-1:0]        r_pend_bc, n_pend_bc;
    logic                 r_pend_first, n_pend_first;
    logic                 r_pend_emit, n_pend_emit;
    logic                 r_pend_last, n_pend_last;

    logic                 r_ovalid, n_ovalid;
    bfd_pkg::t_sample     r_omean, n_omean;
    logic                 r_olast, n_olast;

    logic [bfd_pkg::SUM_BITS-1:0] r_mem [0:bfd_pkg::MAX_WIDTH-1];
    bfd_pkg::t_sum        r_memq;
    logic                 mem_we;
    bfd_pkg::t_sum        mem_wd;

    bfd_pkg::t_factor     f_c;
    bfd_pkg::t_size       w_c;
    bfd_pkg::t_size       h_c;
    logic [DB-1:0]        f_sq;
    logic                 in_acc;
    bfd_pkg::t_sum        samp32;
    bfd_pkg::t_sum        rsum_add;
    bfd_pkg::t_sum        blk_sum;
    logic                 col_edge, row_edge;
    logic [SB:0]          cbeg_f, rbeg_f, cbeg_2f, rbeg_2f;
    logic                 in_col, in_row, col_last, row_last;
    logic                 div_start, div_done;
    bfd_pkg::t_sample     div_q;

    always_comb begin
        if (r_factor == '0) f_c = FB'(1);
        else if (r_factor > FB'(bfd_pkg::MAX_FACTOR)) f_c = FB'(bfd_pkg::MAX_FACTOR);
        else f_c = r_factor;
        if (r_width == '0) w_c = SB'(1);
        else if (r_width > SB'(bfd_pkg::MAX_WIDTH)) w_c = SB'(bfd_pkg::MAX_WIDTH);
        else w_c = r_width;
        if (r_height == '0) h_c = SB'(1);
        else if (r_height > SB'(bfd_pkg::HEIGHT_LIMIT)) h_c = SB'(bfd_pkg::HEIGHT_LIMIT);
        else h_c = r_height;
    end

    assign f_sq     = DB'(f_c) * DB'(f_c);
    assign samp32   = bfd_pkg::t_sum'(i_in.sample);
    assign rsum_add = r_rsum + samp32;
    assign col_edge = ({1'b0, r_cib} + FB'(1)) >= f_c;
    assign row_edge = ({1'b0, r_rib} + FB'(1)) >= f_c;
    assign cbeg_f   = {1'b0, r_cbeg} + (SB+1)'(f_c);
    assign rbeg_f   = {1'b0, r_rbeg} + (SB+1)'(f_c);
    assign cbeg_2f  = cbeg_f + (SB+1)'(f_c);
    assign rbeg_2f  = rbeg_f + (SB+1)'(f_c);
    assign in_col   = cbeg_f <= {1'b0, w_c};
    assign in_row   = rbeg_f <= {1'b0, h_c};
    assign col_last = cbeg_2f > {1'b0, w_c};
    assign row_last = rbeg_2f > {1'b0, h_c};
    assign in_acc   = i_in.valid && (r_state == S_IDLE);
    assign blk_sum  = (r_pend_first ? '0 : r_memq) + r_pend_sum;

    always_comb begin
        n_state      = r_state;
        n_factor     = r_factor;
        n_width      = r_width;
        n_height     = r_height;
        n_col        = r_col;
        n_cib        = r_cib;
        n_bc         = r_bc;
        n_cbeg       = r_cbeg;
        n_row        = r_row;
        n_rib        = r_rib;
        n_rbeg       = r_rbeg;
        n_rsum       = r_rsum;
        n_pend_sum   = r_pend_sum;
        n_pend_bc    = r_pend_bc;
        n_pend_first = r_pend_first;
        n_pend_emit  = r_pend_emit;
        n_pend_last  = r_pend_last;
        n_ovalid     = r_ovalid;
        n_omean      = r_omean;
        n_olast      = r_olast;
        mem_we       = 1'b0;
        mem_wd       = blk_sum;
        div_start    = 1'b0;

        if (r_ovalid && o_out.ready) n_ovalid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (in_col && in_row) begin
                        n_rsum = col_edge ? '0 : rsum_add;
                        if (col_edge) begin
                            n_pend_sum   = rsum_add;
                            n_pend_bc    = r_bc;
                            n_pend_first = (r_rib == '0);
                            n_pend_emit  = row_edge;
                            n_pend_last  = col_last && row_last;
                            n_state      = S_RD;
                        end
                    end
                    n_cib = col_edge ? '0 : r_cib + 1'b1;
                    if (col_edge) begin
                        n_cbeg = cbeg_f[SB-1:0];
                        n_bc   = r_bc + 1'b1;
                    end
                    n_col = r_col + 1'b1;
                    if (({1'b0, r_col} + SB'(1)) >= w_c) begin
                        n_col  = '0;
                        n_cib  = '0;
                        n_cbeg = '0;
                        n_bc   = '0;
                        n_rsum = '0;
                        n_rib  = row_edge ? '0 : r_rib + 1'b1;
                        if (row_edge) n_rbeg = rbeg_f[SB-1:0];
                        n_row  = r_row + 1'b1;
                        if (({1'b0, r_row} + SB'(1)) >= h_c) begin
                            n_row  = '0;
                            n_rib  = '0;
                            n_rbeg = '0;
                        end
                    end
                end
            end
            S_RD: begin
                mem_we = 1'b1;
                if (r_pend_emit) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_omean  = div_q;
                    n_olast  = r_pend_last;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (i_cfg.valid) begin
            if (i_cfg.index == bfd_pkg::REG_FACTOR ||
                i_cfg.index == bfd_pkg::REG_GRID_WIDTH ||
                i_cfg.index == bfd_pkg::REG_GRID_HEIGHT) begin
                n_col  = '0;
                n_cib  = '0;
                n_bc   = '0;
                n_cbeg = '0;
                n_row  = '0;
                n_rib  = '0;
                n_rbeg = '0;
                n_rsum = '0;
            end
            unique case (i_cfg.index)
                bfd_pkg::REG_FACTOR:      n_factor = i_cfg.data[FB-1:0];
                bfd_pkg::REG_GRID_WIDTH:  n_width  = i_cfg.data[SB-1:0];
                bfd_pkg::REG_GRID_HEIGHT: n_height = i_cfg.data[SB-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_factor <= FB'(2);
            r_width  <= SB'(256);
            r_height <= SB'(256);
            r_col    <= '0;
            r_cib    <= '0;
            r_bc     <= '0;
            r_cbeg   <= '0;
            r_row    <= '0;
            r_rib    <= '0;
            r_rbeg   <= '0;
            r_rsum   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_factor <= n_factor;
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_cib    <= n_cib;
            r_bc     <= n_bc;
            r_cbeg   <= n_cbeg;
            r_row    <= n_row;
            r_rib    <= n_rib;
            r_rbeg   <= n_rbeg;
            r_rsum   <= n_rsum;
            r_ovalid <= n_ovalid;
        end
        r_pend_sum   <= n_pend_sum;
        r_pend_bc    <= n_pend_bc;
        r_pend_first <= n_pend_first;
        r_pend_emit  <= n_pend_emit;
        r_pend_last  <= n_pend_last;
        r_omean      <= n_omean;
        r_olast      <= n_olast;
    end

    // column-sum RAM, read address is the current block column
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[r_pend_bc] <= mem_wd;
        r_memq <= r_mem[r_bc];
    end

    bfd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (blk_sum),
        .i_divisor  (f_sq),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    assign i_in.ready       = (r_state == S_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_ovalid;
    assign o_out.block_mean = r_omean;
    assign o_out.frame_last = r_olast;

endmodule

@@ rtl/bfd_div.sv @@
// ----------------------------------------------------------------------------
// bfd_div
// Radix-2 restoring divider: signed block sum over factor squared,
// truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bfd_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  bfd_pkg::t_sum                       i_dividend,
    input  logic [bfd_pkg::DIVISOR_BITS-1:0]    i_divisor,
    output logic                                o_done,
    output bfd_pkg::t_sample                    o_quot
);

    localparam int CNT_BITS = $clog2(bfd_pkg::SUM_BITS);

    logic                              r_busy, n_busy;
    logic                              r_done, n_done;
    logic [CNT_BITS-1:0]               r_cnt, n_cnt;
    logic [bfd_pkg::DIVISOR_BITS-1:0]  r_rem, n_rem;
    logic [bfd_pkg::DIVISOR_BITS-1:0]  r_dvs, n_dvs;
    logic [bfd_pkg::SUM_BITS-1:0]      r_quo, n_quo;
    logic                              r_neg, n_neg;

    logic [bfd_pkg::DIVISOR_BITS:0]    trial;
    logic [bfd_pkg::DIVISOR_BITS:0]    diff;
    logic                              qbit;
    logic [bfd_pkg::SUM_BITS-1:0]      q_signed;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_quo  = r_quo;
        n_neg  = r_neg;
        trial  = {r_rem, r_quo[bfd_pkg::SUM_BITS-1]};
        diff   = trial - {1'b0, r_dvs};
        qbit   = (trial >= {1'b0, r_dvs});
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvs  = i_divisor;
            n_neg  = i_dividend[bfd_pkg::SUM_BITS-1];
            n_quo  = i_dividend[bfd_pkg::SUM_BITS-1] ? (-i_dividend) : i_dividend;
        end else if (r_busy) begin
            n_rem = qbit ? diff[bfd_pkg::DIVISOR_BITS-1:0] : trial[bfd_pkg::DIVISOR_BITS-1:0];
            n_quo = {r_quo[bfd_pkg::SUM_BITS-2:0], qbit};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_BITS'(bfd_pkg::SUM_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_quo <= n_quo;
        r_neg <= n_neg;
    end

    assign q_signed = r_neg ? (-r_quo) : r_quo;
    assign o_quot   = q_signed[bfd_pkg::SAMPLE_BITS-1:0];
    assign o_done   = r_done;

endmodule
